// ===== rtl/cpu16_mov_add_sub_cmp_unit_top_assert.svh =====
// ----------------------------------------------------------------------------
// cpu16 alu assertion macros
// concurrent assertion shorthands clocked on clk, quiet while rst_n is low
// ----------------------------------------------------------------------------
`ifndef CPU16_MOV_ADD_SUB_CMP_UNIT_TOP_ASSERT_SVH
`define CPU16_MOV_ADD_SUB_CMP_UNIT_TOP_ASSERT_SVH

// property must hold at every clock edge outside reset
`define C16ALU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define C16ALU_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/c16alu_pkg.sv =====
// ----------------------------------------------------------------------------
// c16alu package
// shared types and constants of the 16-bit mov/add/sub/cmp execute unit
// ----------------------------------------------------------------------------
package c16alu_pkg;

    localparam int unsigned NUM_REGS  = 12;
    localparam int unsigned REG_IDX_W = 4;
    localparam int unsigned DATA_W    = 16;
    localparam int unsigned BYTE_W    = 8;

    typedef enum logic [1:0] {
        OP_MOV = 2'd0,
        OP_ADD = 2'd1,
        OP_SUB = 2'd2,
        OP_CMP = 2'd3
    } op_t;

    // command transaction as it arrives
    typedef struct packed {
        op_t                  op;
        logic                 wide;
        logic [3:0]           dst_reg;
        logic                 src_is_imm;
        logic [3:0]           src_reg;
        logic [DATA_W-1:0]    imm_value;
    } cmd_t;

    // response transaction
    typedef struct packed {
        logic [DATA_W-1:0]    dst_value;
        logic                 carry;
        logic                 parity;
        logic                 aux_carry;
        logic                 zero;
        logic                 sign;
        logic                 overflow;
    } rsp_t;

    // status flags as kept in the back end
    typedef struct packed {
        logic                 overflow;
        logic                 sign;
        logic                 zero;
        logic                 aux_carry;
        logic                 parity;
        logic                 carry;
    } flags_t;

    // decoded operation passed from front end to back end
    typedef struct packed {
        op_t                  op;
        logic                 wide;
        logic [REG_IDX_W-1:0] dst_idx;
        logic                 dst_hi;
        logic                 dst_ok;
        logic                 src_is_imm;
        logic [REG_IDX_W-1:0] src_idx;
        logic                 src_hi;
        logic                 src_ok;
        logic [DATA_W-1:0]    imm;
    } uop_t;

endpackage

// ===== rtl/c16alu_front.sv =====
// ----------------------------------------------------------------------------
// c16alu front end
// takes command transactions and decodes register codes into word slots
// ----------------------------------------------------------------------------
module c16alu_front (
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  c16alu_pkg::cmd_t  cmd,
    output logic              push_valid,
    input  logic              push_ready,
    output c16alu_pkg::uop_t  push_data
);
    import c16alu_pkg::*;

    logic dst_in_range;
    logic src_in_range;

    assign cmd_ready  = push_ready;
    assign push_valid = cmd_valid;

    assign dst_in_range = (cmd.dst_reg < REG_IDX_W'(NUM_REGS));
    assign src_in_range = (cmd.src_reg < REG_IDX_W'(NUM_REGS));

    always_comb
    begin
        push_data.op         = cmd.op;
        push_data.wide       = cmd.wide;
        push_data.src_is_imm = cmd.src_is_imm;
        if (cmd.wide)
        begin
            // word codes past the last register read as zero, writes dropped
            push_data.dst_idx = dst_in_range ? cmd.dst_reg : '0;
            push_data.dst_hi  = 1'b0;
            push_data.dst_ok  = dst_in_range;
            push_data.src_idx = src_in_range ? cmd.src_reg : '0;
            push_data.src_hi  = 1'b0;
            push_data.src_ok  = src_in_range;
            push_data.imm     = cmd.imm_value;
        end
        else
        begin
            // byte codes: bit 2 picks the high half of word 0-3, bit 3 ignored
            push_data.dst_idx = {2'b00, cmd.dst_reg[1:0]};
            push_data.dst_hi  = cmd.dst_reg[2];
            push_data.dst_ok  = 1'b1;
            push_data.src_idx = {2'b00, cmd.src_reg[1:0]};
            push_data.src_hi  = cmd.src_reg[2];
            push_data.src_ok  = 1'b1;
            push_data.imm     = {{(DATA_W-BYTE_W){1'b0}}, cmd.imm_value[BYTE_W-1:0]};
        end
    end

endmodule

// ===== rtl/c16alu_queue.sv =====
// ----------------------------------------------------------------------------
// c16alu queue
// short fifo of decoded operations between front end and back end
// ----------------------------------------------------------------------------
module c16alu_queue #(
    parameter int unsigned Depth = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  c16alu_pkg::uop_t  push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output c16alu_pkg::uop_t  pop_data
);
    import c16alu_pkg::*;

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    uop_t            entry_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            push_fire;
    logic            pop_fire;

    assign push_ready = (count_reg != CntW'(Depth));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    assign wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        unique case ({push_fire, pop_fire})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_fire)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/c16alu_back.sv =====
// ----------------------------------------------------------------------------
// c16alu back end
// register file read, alu and flags, write back and response register
// ----------------------------------------------------------------------------
module c16alu_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  c16alu_pkg::uop_t  pop_data,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output c16alu_pkg::rsp_t  rsp
);
    import c16alu_pkg::*;

    // register file and its per-entry valid bits
    logic [DATA_W-1:0]    rf_mem_reg [NUM_REGS];
    logic [NUM_REGS-1:0]  rf_valid_reg;

    // execute stage
    logic                 ex_valid_reg;
    uop_t                 ex_uop_reg;
    logic [DATA_W-1:0]    dst_word_reg;
    logic [DATA_W-1:0]    src_word_reg;
    logic                 dst_vld_reg;
    logic                 src_vld_reg;

    // last write, forwarded to the read that raced it
    logic                 lw_valid_reg;
    logic [REG_IDX_W-1:0] lw_idx_reg;
    logic [DATA_W-1:0]    lw_data_reg;

    flags_t               flags_reg;
    flags_t               flags_next;
    logic                 rsp_valid_reg;
    rsp_t                 rsp_reg;
    rsp_t                 rsp_next;

    logic                 issue;
    logic                 ex_fire;
    logic [DATA_W-1:0]    a_word;
    logic [DATA_W-1:0]    s_word;
    logic [BYTE_W-1:0]    a_byte;
    logic [BYTE_W-1:0]    s_byte;
    logic [DATA_W-1:0]    opa;
    logic [DATA_W-1:0]    opb;
    logic                 is_sub;
    logic [DATA_W:0]      sum_w;
    logic [DATA_W:0]      diff_w;
    logic [DATA_W:0]      raw;
    logic [4:0]           nib_sum;
    logic [4:0]           nib_diff;
    logic [DATA_W-1:0]    res;
    logic                 msb_a;
    logic                 msb_b;
    logic                 msb_r;
    logic [DATA_W-1:0]    wr_val;
    logic [DATA_W-1:0]    wr_word;
    logic                 wr_en;

    assign ex_fire   = ex_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign pop_ready = !ex_valid_reg || ex_fire;
    assign issue     = pop_valid && pop_ready;

    // operand words with forwarding of the write made on the read edge
    always_comb
    begin
        if (!ex_uop_reg.dst_ok)
            a_word = '0;
        else if (lw_valid_reg && (lw_idx_reg == ex_uop_reg.dst_idx))
            a_word = lw_data_reg;
        else
            a_word = dst_vld_reg ? dst_word_reg : '0;

        if (!ex_uop_reg.src_ok)
            s_word = '0;
        else if (lw_valid_reg && (lw_idx_reg == ex_uop_reg.src_idx))
            s_word = lw_data_reg;
        else
            s_word = src_vld_reg ? src_word_reg : '0;
    end

    assign a_byte = ex_uop_reg.dst_hi ? a_word[DATA_W-1:BYTE_W] : a_word[BYTE_W-1:0];
    assign s_byte = ex_uop_reg.src_hi ? s_word[DATA_W-1:BYTE_W] : s_word[BYTE_W-1:0];

    assign opa = ex_uop_reg.wide ? a_word : {{(DATA_W-BYTE_W){1'b0}}, a_byte};
    assign opb = ex_uop_reg.src_is_imm ? ex_uop_reg.imm :
                 ex_uop_reg.wide       ? s_word :
                                         {{(DATA_W-BYTE_W){1'b0}}, s_byte};

    // alu
    assign is_sub   = (ex_uop_reg.op != OP_ADD);
    assign sum_w    = {1'b0, opa} + {1'b0, opb};
    assign diff_w   = {1'b0, opa} - {1'b0, opb};
    assign nib_sum  = {1'b0, opa[3:0]} + {1'b0, opb[3:0]};
    assign nib_diff = {1'b0, opa[3:0]} - {1'b0, opb[3:0]};
    assign raw      = is_sub ? diff_w : sum_w;
    assign res      = ex_uop_reg.wide ? raw[DATA_W-1:0]
                                      : {{(DATA_W-BYTE_W){1'b0}}, raw[BYTE_W-1:0]};

    assign msb_a = ex_uop_reg.wide ? opa[DATA_W-1] : opa[BYTE_W-1];
    assign msb_b = ex_uop_reg.wide ? opb[DATA_W-1] : opb[BYTE_W-1];
    assign msb_r = ex_uop_reg.wide ? res[DATA_W-1] : res[BYTE_W-1];

    always_comb
    begin
        if (ex_uop_reg.op == OP_MOV)
        begin
            flags_next = flags_reg;
        end
        else
        begin
            flags_next.carry     = ex_uop_reg.wide ? raw[DATA_W] : raw[BYTE_W];
            flags_next.parity    = ~^res[BYTE_W-1:0];
            flags_next.aux_carry = is_sub ? nib_diff[4] : nib_sum[4];
            flags_next.zero      = (res == '0);
            flags_next.sign      = msb_r;
            flags_next.overflow  = is_sub ? ((msb_a ^ msb_b) & (msb_a ^ msb_r))
                                          : (~(msb_a ^ msb_b) & (msb_a ^ msb_r));
        end
    end

    // write back: byte writes merge into the current word
    assign wr_val = (ex_uop_reg.op == OP_MOV) ? opb : res;
    always_comb
    begin
        if (ex_uop_reg.wide)
            wr_word = wr_val;
        else if (ex_uop_reg.dst_hi)
            wr_word = {wr_val[BYTE_W-1:0], a_word[BYTE_W-1:0]};
        else
            wr_word = {a_word[DATA_W-1:BYTE_W], wr_val[BYTE_W-1:0]};
    end
    assign wr_en = ex_fire && ex_uop_reg.dst_ok && (ex_uop_reg.op != OP_CMP);

    always_comb
    begin
        if (!ex_uop_reg.dst_ok)
            rsp_next.dst_value = '0;
        else if (ex_uop_reg.op == OP_CMP)
            rsp_next.dst_value = opa;
        else
            rsp_next.dst_value = wr_val;
        rsp_next.carry     = flags_next.carry;
        rsp_next.parity    = flags_next.parity;
        rsp_next.aux_carry = flags_next.aux_carry;
        rsp_next.zero      = flags_next.zero;
        rsp_next.sign      = flags_next.sign;
        rsp_next.overflow  = flags_next.overflow;
    end

    // register file storage and operand reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rf_mem_reg[ex_uop_reg.dst_idx] <= wr_word;
        end
        if (issue)
        begin
            dst_word_reg <= rf_mem_reg[pop_data.dst_idx];
            src_word_reg <= rf_mem_reg[pop_data.src_idx];
            ex_uop_reg   <= pop_data;
        end
        if (wr_en)
        begin
            lw_idx_reg  <= ex_uop_reg.dst_idx;
            lw_data_reg <= wr_word;
        end
        if (ex_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg  <= '0;
            dst_vld_reg   <= 1'b0;
            src_vld_reg   <= 1'b0;
            ex_valid_reg  <= 1'b0;
            lw_valid_reg  <= 1'b0;
            flags_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                rf_valid_reg[ex_uop_reg.dst_idx] <= 1'b1;
                lw_valid_reg                     <= 1'b1;
            end
            if (issue)
            begin
                dst_vld_reg <= rf_valid_reg[pop_data.dst_idx];
                src_vld_reg <= rf_valid_reg[pop_data.src_idx];
            end
            if (pop_ready)
            begin
                ex_valid_reg <= pop_valid;
            end
            if (ex_fire)
            begin
                flags_reg     <= flags_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== rtl/cpu16_mov_add_sub_cmp_unit_top.sv =====
// ----------------------------------------------------------------------------
// cpu16 mov/add/sub/cmp execute unit
// register/immediate mov, add, sub, cmp on twelve 16-bit registers and flags
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------
//  cmd     | in        | cmd_valid / cmd_ready | cmd_t: op, width, regs, imm
//  rsp     | out       | rsp_valid / rsp_ready | rsp_t: dst value, six flags
//
//  one transaction per cycle sustained while rsp is not stalled, set by the register file
//  read-modify-write, one alu pass per cycle in the execute stage
//  a taken cmd transaction reaches rsp_valid through the queue, then register
//  read, then execute into the response register
//  reset clears queue, valids, flags and register valid bits; no sweep
//  a stalled rsp holds execute, the queue fills, then cmd_ready drops
//
module cpu16_mov_add_sub_cmp_unit_top #(
    parameter int unsigned QueueDepth = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  c16alu_pkg::cmd_t  cmd,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output c16alu_pkg::rsp_t  rsp
);
    import c16alu_pkg::*;

    // decoded operations from the front end into the queue
    logic push_valid;
    logic push_ready;
    uop_t push_data;

    // queue out to the back end
    logic pop_valid;
    logic pop_ready;
    uop_t pop_data;

    // front end: register code decode, byte/word slot mapping
    c16alu_front u_front (
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // short queue so front and back stall independently
    c16alu_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // back end: register file, alu, flags and response register
    c16alu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

endmodule

// ===== rtl/c16alu_chk.sv =====
// ----------------------------------------------------------------------------
// c16alu port checker
// watches the top level ports for ordering and stall behavior
// ----------------------------------------------------------------------------
`include "cpu16_mov_add_sub_cmp_unit_top_assert.svh"

module c16alu_chk (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  logic              cmd_ready,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  c16alu_pkg::rsp_t  rsp
);
    import c16alu_pkg::*;

    // transactions taken on cmd and not yet delivered on rsp
    logic [7:0] pend_reg;
    logic       cmd_fire;
    logic       rsp_fire;

    assign cmd_fire = cmd_valid && cmd_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            unique case ({cmd_fire, rsp_fire})
                2'b10:   pend_reg <= pend_reg + 1'b1;
                2'b01:   pend_reg <= pend_reg - 1'b1;
                default: pend_reg <= pend_reg;
            endcase
        end
    end

    // a response needs a command behind it
    `C16ALU_ASSERT_NEVER(a_rsp_without_cmd, rsp_valid && (pend_reg == 8'd0), "rsp without cmd")

    // an empty unit always takes a command
    `C16ALU_ASSERT(a_ready_when_idle, (pend_reg == 8'd0) |-> cmd_ready, "cmd_ready low when idle")

    // a stalled response holds
    `C16ALU_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)), "rsp dropped")

endmodule

bind cpu16_mov_add_sub_cmp_unit_top c16alu_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

// ===== tb/sv/tb_cpu16_mov_add_sub_cmp_unit_top.sv =====
// ----------------------------------------------------------------------------
// cpu16 mov/add/sub/cmp execute unit testbench
// drives directed and random register/immediate instructions through the cmd
// channel under random bursts and rsp back-pressure, predicts the register
// file and flags in a scoreboard and checks every rsp transaction in order
// ----------------------------------------------------------------------------
module tb_cpu16_mov_add_sub_cmp_unit_top;

    import c16alu_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 2000;
    localparam int unsigned REPORT_LIMIT = 10;
    localparam int unsigned HOLD_START   = 300;   // receiver cycle where the long stall begins
    localparam int unsigned HOLD_LEN     = 200;
    localparam int unsigned DRAIN_LIMIT  = 5000;
    localparam int unsigned TAIL_CYCLES  = 8;     // margin for stray responses after the drain

    // ------------------------------------------------------------------------
    // scoreboard: shadow register file and flags, queue of expected responses
    // ------------------------------------------------------------------------
    class c16_exec_tracker;
        logic [DATA_W-1:0] shadow_regs [NUM_REGS];
        flags_t            shadow_flags;
        rsp_t              want_rsp [$];
        int unsigned       fails;

        function new();
            foreach (shadow_regs[i])
                shadow_regs[i] = '0;
            shadow_flags = '0;
            fails        = 0;
        endfunction

        // word codes past the file read zero; byte codes use the low three bits
        function logic [DATA_W-1:0] fetch(logic [3:0] code, logic wide);
            logic [DATA_W-1:0] word;
            if (wide)
                return (code < NUM_REGS) ? shadow_regs[code] : '0;
            word = shadow_regs[code[1:0]];
            return code[2] ? {8'h00, word[15:8]} : {8'h00, word[7:0]};
        endfunction

        function void store(logic [3:0] code, logic wide, logic [DATA_W-1:0] val);
            if (wide)
            begin
                if (code < NUM_REGS)
                    shadow_regs[code] = val;
            end
            else if (code[2])
                shadow_regs[code[1:0]][15:8] = val[7:0];
            else
                shadow_regs[code[1:0]][7:0] = val[7:0];
        endfunction

        function void fail_note(string what);
            fails++;
            if (fails <= REPORT_LIMIT)
                $display("[%0t] %s", $time, what);
        endfunction

        // executes one accepted command and queues the response it must give
        function void take_cmd(cmd_t c);
            logic [DATA_W-1:0] mask;
            logic [DATA_W-1:0] msb;
            logic [DATA_W-1:0] a;
            logic [DATA_W-1:0] b;
            logic [DATA_W-1:0] res;
            logic [DATA_W:0]   full;
            logic [4:0]        nib;
            rsp_t              exp_rsp;
            mask = c.wide ? 16'hFFFF : 16'h00FF;
            msb  = c.wide ? 16'h8000 : 16'h0080;
            a    = fetch(c.dst_reg, c.wide);
            b    = c.src_is_imm ? (c.imm_value & mask) : fetch(c.src_reg, c.wide);
            if (c.op == OP_MOV)
                store(c.dst_reg, c.wide, b);
            else
            begin
                if (c.op == OP_ADD)
                begin
                    full = {1'b0, a} + {1'b0, b};
                    res  = full[DATA_W-1:0] & mask;
                    nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]};
                    shadow_flags.carry     = full > {1'b0, mask};
                    shadow_flags.aux_carry = nib[4];
                    shadow_flags.overflow  = |(~(a ^ b) & (a ^ res) & msb);
                end
                else
                begin
                    // sub and cmp: carry and aux are borrows
                    res = (a - b) & mask;
                    shadow_flags.carry     = a < b;
                    shadow_flags.aux_carry = a[3:0] < b[3:0];
                    shadow_flags.overflow  = |((a ^ b) & (a ^ res) & msb);
                end
                shadow_flags.parity = ~^res[7:0];
                shadow_flags.zero   = (res == '0);
                shadow_flags.sign   = |(res & msb);
                if (c.op != OP_CMP)
                    store(c.dst_reg, c.wide, res);
            end
            exp_rsp.dst_value = fetch(c.dst_reg, c.wide);
            exp_rsp.carry     = shadow_flags.carry;
            exp_rsp.parity    = shadow_flags.parity;
            exp_rsp.aux_carry = shadow_flags.aux_carry;
            exp_rsp.zero      = shadow_flags.zero;
            exp_rsp.sign      = shadow_flags.sign;
            exp_rsp.overflow  = shadow_flags.overflow;
            want_rsp.push_back(exp_rsp);
        endfunction

        function void check_rsp(rsp_t got);
            rsp_t exp_rsp;
            if (want_rsp.size() == 0)
            begin
                fail_note($sformatf("unexpected rsp transaction %h", got));
                return;
            end
            exp_rsp = want_rsp.pop_front();
            if (got.dst_value !== exp_rsp.dst_value || got.carry !== exp_rsp.carry ||
                got.parity !== exp_rsp.parity || got.aux_carry !== exp_rsp.aux_carry ||
                got.zero !== exp_rsp.zero || got.sign !== exp_rsp.sign ||
                got.overflow !== exp_rsp.overflow)
                fail_note($sformatf(
                    "rsp mismatch: exp %h c%b p%b a%b z%b s%b o%b, got %h c%b p%b a%b z%b s%b o%b",
                    exp_rsp.dst_value, exp_rsp.carry, exp_rsp.parity, exp_rsp.aux_carry,
                    exp_rsp.zero, exp_rsp.sign, exp_rsp.overflow,
                    got.dst_value, got.carry, got.parity, got.aux_carry,
                    got.zero, got.sign, got.overflow));
        endfunction

        function void finish_check();
            if (want_rsp.size() != 0)
                fail_note($sformatf("%0d rsp transactions never arrived", want_rsp.size()));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and dut
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    c16_exec_tracker tracker = new();

    always #10 clk = ~clk;

    cpu16_mov_add_sub_cmp_unit_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // ------------------------------------------------------------------------
    // monitors: sample both channels at the rising edge
    // ------------------------------------------------------------------------
    // a cmd and a rsp taken at the same edge are unrelated (a cmd is registered
    // before its own rsp), so the order of these two blocks does not matter
    always @(posedge clk)
    begin
        if (rst_n && cmd_valid && cmd_ready)
            tracker.take_cmd(cmd);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            tracker.check_rsp(rsp);
    end

    // ------------------------------------------------------------------------
    // driver tasks, called at a falling edge and returning at one
    // ------------------------------------------------------------------------
    // holds the transaction until the block takes it
    task automatic offer_cmd(input cmd_t c);
        cmd       <= c;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cmd_ready);
        @(negedge clk);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        if (cycles != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    function automatic cmd_t mk_cmd(op_t op, logic wide, logic [3:0] dst, logic use_imm,
                                    logic [3:0] src, logic [15:0] imm);
        cmd_t c;
        c.op         = op;
        c.wide       = wide;
        c.dst_reg    = dst;
        c.src_is_imm = use_imm;
        c.src_reg    = src;
        c.imm_value  = imm;
        return c;
    endfunction

    // mostly legal codes, now and then one of the unused codes 12-15
    function automatic logic [3:0] pick_code();
        if ($urandom_range(0, 7) == 0)
            return 4'($urandom_range(12, 15));
        return 4'($urandom_range(0, NUM_REGS - 1));
    endfunction

    // ------------------------------------------------------------------------
    // receiver: random stall pattern plus one long hold-off
    // ------------------------------------------------------------------------
    // modes: 0 always ready, 1 half, 2 mostly stalled, 3 mostly ready
    initial
    begin
        int unsigned rx_cycles;
        int unsigned mode;
        int unsigned seg;
        rx_cycles = 0;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(5, 60);
            repeat (seg)
            begin
                @(negedge clk);
                rx_cycles++;
                // long stall: queue and pipe fill, cmd_ready must drop
                if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_LEN)
                    rsp_ready <= 1'b0;
                else
                    case (mode)
                        0:       rsp_ready <= 1'b1;
                        1:       rsp_ready <= 1'($urandom_range(0, 1));
                        2:       rsp_ready <= ($urandom_range(0, 3) == 0);
                        default: rsp_ready <= ($urandom_range(0, 7) != 0);
                    endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        #10_000_000;
        $display("cpu16_mov_add_sub_cmp_unit_top regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        cmd_t        c;
        int unsigned sent;
        int unsigned burst;
        int unsigned waited;
        int unsigned pick;

        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extremes, every op, both widths and the odd register codes
        offer_cmd(mk_cmd(OP_MOV, 1'b1, 4'd0,  1'b1, 4'd0,  16'hFFFF));
        offer_cmd(mk_cmd(OP_ADD, 1'b1, 4'd0,  1'b1, 4'd0,  16'h0001)); // wrap to zero, carry
        offer_cmd(mk_cmd(OP_MOV, 1'b1, 4'd1,  1'b1, 4'd0,  16'h7FFF));
        offer_cmd(mk_cmd(OP_ADD, 1'b1, 4'd1,  1'b1, 4'd0,  16'h0001)); // signed overflow
        offer_cmd(mk_cmd(OP_SUB, 1'b1, 4'd2,  1'b1, 4'd0,  16'h0001)); // borrow from zero
        offer_cmd(mk_cmd(OP_CMP, 1'b1, 4'd1,  1'b0, 4'd0,  16'h0000)); // dest untouched
        offer_cmd(mk_cmd(OP_SUB, 1'b1, 4'd1,  1'b0, 4'd2,  16'h0000)); // 8000 - ffff
        offer_cmd(mk_cmd(OP_MOV, 1'b0, 4'd4,  1'b1, 4'd0,  16'hAB80)); // high byte, low imm byte
        offer_cmd(mk_cmd(OP_ADD, 1'b0, 4'd4,  1'b1, 4'd0,  16'h0080)); // byte carry and overflow
        offer_cmd(mk_cmd(OP_MOV, 1'b0, 4'd0,  1'b1, 4'd0,  16'h007F));
        offer_cmd(mk_cmd(OP_ADD, 1'b0, 4'd0,  1'b0, 4'd0,  16'h0000)); // 7f + 7f
        offer_cmd(mk_cmd(OP_SUB, 1'b0, 4'd7,  1'b0, 4'd0,  16'h0000));
        offer_cmd(mk_cmd(OP_CMP, 1'b0, 4'd3,  1'b1, 4'd0,  16'h00FF));
        offer_cmd(mk_cmd(OP_MOV, 1'b1, 4'd13, 1'b1, 4'd0,  16'h1234)); // unused word code
        offer_cmd(mk_cmd(OP_ADD, 1'b1, 4'd12, 1'b1, 4'd0,  16'hFFFF)); // flags still kept
        offer_cmd(mk_cmd(OP_MOV, 1'b1, 4'd8,  1'b0, 4'd15, 16'h0000)); // unused source reads 0
        offer_cmd(mk_cmd(OP_ADD, 1'b1, 4'd11, 1'b0, 4'd0,  16'h0000)); // last register
        offer_cmd(mk_cmd(OP_MOV, 1'b0, 4'd12, 1'b1, 4'd0,  16'h0055)); // byte code aliases 4
        offer_cmd(mk_cmd(OP_SUB, 1'b0, 4'd15, 1'b0, 4'd9,  16'h0000)); // aliases 7 and 1
        offer_cmd(mk_cmd(OP_CMP, 1'b1, 4'd0,  1'b0, 4'd0,  16'h0000));
        offer_cmd(mk_cmd(OP_SUB, 1'b0, 4'd1,  1'b1, 4'd0,  16'h0010)); // byte borrow
        offer_cmd(mk_cmd(OP_ADD, 1'b0, 4'd1,  1'b1, 4'd0,  16'h000F)); // nibble carry

        // random bursts with random gaps
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 24);
            repeat (burst)
            begin
                c.op         = op_t'($urandom_range(0, 3));
                c.wide       = 1'($urandom_range(0, 1));
                c.dst_reg    = pick_code();
                c.src_reg    = pick_code();
                c.src_is_imm = 1'($urandom_range(0, 1));
                // bias immediates toward sign, nibble and wrap boundaries
                pick = $urandom_range(0, 11);
                case (pick)
                    0:       c.imm_value = 16'h0000;
                    1:       c.imm_value = 16'hFFFF;
                    2:       c.imm_value = 16'h7FFF;
                    3:       c.imm_value = 16'h8000;
                    4:       c.imm_value = 16'(8'($urandom_range(0, 255)) ^ 16'h0080);
                    5:       c.imm_value = 16'($urandom_range(0, 16));
                    default: c.imm_value = 16'($urandom_range(0, 65535));
                endcase
                offer_cmd(c);
                sent++;
            end
            pause_sender(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
        end
        cmd_valid <= 1'b0;

        // drain, then allow stray responses to show up
        waited = 0;
        while (tracker.want_rsp.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        tracker.finish_check();

        if (tracker.fails == 0)
            $display("cpu16_mov_add_sub_cmp_unit_top regression: pass");
        else
            $display("cpu16_mov_add_sub_cmp_unit_top regression: fail");
        $finish;
    end

endmodule
